[rtl/snsl_pkg.sv]
// snsl_pkg: shared types, codes and constants for the sorted set with list parser
// no dependencies
package snsl_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam logic [63:0] INT64_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

  // request opcodes
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_REM   = 3'd1,
    OP_CONT  = 3'd2,
    OP_PEEK  = 3'd3,
    OP_POP   = 3'd4,
    OP_CLR   = 3'd5,
    OP_PARSE = 3'd6
  } op_t;

  // character classes for the list parser
  typedef enum logic [1:0] {
    CH_NUL   = 2'd0,
    CH_DIGIT = 2'd1,
    CH_SEP   = 2'd2,
    CH_BAD   = 2'd3
  } chcls_t;

  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_NUL   = 8'h00;

  // classified request handed from front to back
  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] value;
    chcls_t      cls;
    logic [3:0]  digit;
  } cmd_t;

  function automatic chcls_t classify(input logic [7:0] c);
    chcls_t r;
    if (c == CHR_NUL) r = CH_NUL;
    else if (c >= CHR_ZERO && c <= CHR_NINE) r = CH_DIGIT;
    else if (c == CHR_COMMA || c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR)) r = CH_SEP;
    else r = CH_BAD;
    return r;
  endfunction

endpackage

[rtl/sorted_number_set_with_list_parser_top.sv]
// a request is held in the front queue, then executed, and its result is held in the result register until taken
// throughput: one request per cycle while out_ready is high; each is done in one pass over the compare-and-shift cells
// the front queue holds 2 requests, so input can still take requests while a result waits, until the queue is full
// reset (rst_n low, synchronous): set empty, parser idle with list success set, no results
// stored values need no clearing; entries above the count are never read
module sorted_number_set_with_list_parser_top #(
  parameter int unsigned SET_CAPACITY = snsl_pkg::CAPACITY_DEF,
  parameter int unsigned CW = $clog2(SET_CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_opcode,
  input  logic signed [63:0] in_value,
  input  logic [7:0]         in_char_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic               out_full_res,
  output logic signed [63:0] out_min_value,
  output logic [CW-1:0]      out_count,
  output logic               out_parse_error,
  output logic               out_parse_done
);

  logic q_valid, q_ready;
  snsl_pkg::cmd_t q_cmd;

  snsl_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_value, .in_char_code,
    .q_valid, .q_ready, .q_cmd
  );

  snsl_back #(.CAP(SET_CAPACITY), .CW(CW)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .out_valid, .out_ready, .out_ok, .out_full_res, .out_min_value,
    .out_count, .out_parse_error, .out_parse_done
  );

endmodule

[rtl/snsl_front.sv]
// snsl_front: accepts requests, classifies the list character, two-entry queue
// depends on snsl_pkg
module snsl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_opcode,
  input  logic signed [63:0]  in_value,
  input  logic [7:0]          in_char_code,
  output logic                q_valid,
  input  logic                q_ready,
  output snsl_pkg::cmd_t      q_cmd
);

  snsl_pkg::cmd_t slot_r [2];
  snsl_pkg::cmd_t new_cmd;
  logic wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push, pop;

  // classify incoming request
  always_comb begin
    new_cmd.opcode = in_opcode;
    new_cmd.value  = in_value;
    new_cmd.cls    = snsl_pkg::classify(in_char_code);
    new_cmd.digit  = 4'(in_char_code - snsl_pkg::CHR_ZERO);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = slot_r[rp_r];

  // queue pointers
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= new_cmd;
  end

endmodule

[rtl/snsl_back.sv]
// snsl_back: executes requests on the compare-and-shift cell row and the parser
// depends on snsl_pkg
module snsl_back #(
  parameter int unsigned CAP = snsl_pkg::CAPACITY_DEF,
  parameter int unsigned CW  = $clog2(CAP + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  snsl_pkg::cmd_t     q_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic               out_full_res,
  output logic signed [63:0] out_min_value,
  output logic [CW-1:0]      out_count,
  output logic               out_parse_error,
  output logic               out_parse_done
);

  logic [63:0] vals_r [CAP];
  logic [63:0] vals_nxt [CAP];
  logic [CW-1:0] count_r, count_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic started_r, started_nxt, success_r, success_nxt, aborted_r, aborted_nxt;

  logic ovld_r;
  logic o_ok_r, o_full_r, o_perr_r, o_done_r;
  logic [63:0] o_min_r;
  logic [CW-1:0] o_cnt_r;
  logic r_ok, r_full, r_perr, r_done;
  logic [63:0] r_min;

  logic go;
  logic [63:0] key;
  logic [CAP-1:0] lt, eq;
  logic found, is_full, ins_req, ins_ok, rem_req, do_ins, do_rem;
  logic [67:0] prod;
  logic ovf;

  assign q_ready = !ovld_r || out_ready;
  assign go      = q_valid && q_ready;
  assign is_full = (count_r == CW'(CAP));

  // search key
  always_comb begin
    case (q_cmd.opcode)
      snsl_pkg::OP_PARSE:                  key = acc_r;
      snsl_pkg::OP_PEEK, snsl_pkg::OP_POP: key = vals_r[0];
      default:                             key = q_cmd.value;
    endcase
  end

  // per-cell compares
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      lt[i] = (CW'(i) < count_r) && ($signed(vals_r[i]) < $signed(key));
      eq[i] = (CW'(i) < count_r) && (vals_r[i] == key);
    end
  end
  assign found  = |eq;
  assign ins_ok = !found && !is_full;

  // digit accumulate with overflow check
  assign prod = {acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {64'd0, q_cmd.digit};
  assign ovf  = (prod > {4'd0, snsl_pkg::INT64_TOP});

  // request decode and parser
  always_comb begin
    acc_nxt     = acc_r;
    started_nxt = started_r;
    success_nxt = success_r;
    aborted_nxt = aborted_r;
    ins_req     = 1'b0;
    rem_req     = 1'b0;
    r_ok        = 1'b0;
    r_full      = 1'b0;
    r_min       = 64'd0;
    r_perr      = 1'b0;
    r_done      = 1'b0;
    unique case (q_cmd.opcode)
      snsl_pkg::OP_ADD: begin
        ins_req = 1'b1;
        r_ok    = ins_ok;
        r_full  = !found && is_full;
      end
      snsl_pkg::OP_REM: begin
        rem_req = 1'b1;
        r_ok    = found;
      end
      snsl_pkg::OP_CONT: r_ok = found;
      snsl_pkg::OP_PEEK, snsl_pkg::OP_POP: begin
        r_ok    = (count_r != '0);
        r_min   = r_ok ? vals_r[0] : 64'd0;
        rem_req = (q_cmd.opcode == snsl_pkg::OP_POP);
      end
      snsl_pkg::OP_CLR: r_ok = 1'b1;
      snsl_pkg::OP_PARSE: begin
        if (q_cmd.cls == snsl_pkg::CH_NUL) begin
          ins_req     = !aborted_r && started_r;
          r_full      = ins_req && !found && is_full;
          r_ok        = success_r && !(ins_req && !ins_ok);
          r_perr      = aborted_r;
          r_done      = 1'b1;
          acc_nxt     = 64'd0;
          started_nxt = 1'b0;
          success_nxt = 1'b1;
          aborted_nxt = 1'b0;
        end else begin
          if (!aborted_r) begin
            unique case (q_cmd.cls)
              snsl_pkg::CH_DIGIT: begin
                if (ovf) begin
                  aborted_nxt = 1'b1;
                  success_nxt = 1'b0;
                  acc_nxt     = 64'd0;
                  started_nxt = 1'b0;
                end else begin
                  acc_nxt     = prod[63:0];
                  started_nxt = 1'b1;
                end
              end
              snsl_pkg::CH_SEP: begin
                ins_req     = started_r;
                r_full      = ins_req && !found && is_full;
                if (ins_req && !ins_ok) success_nxt = 1'b0;
                acc_nxt     = 64'd0;
                started_nxt = 1'b0;
              end
              default: begin
                aborted_nxt = 1'b1;
                success_nxt = 1'b0;
                acc_nxt     = 64'd0;
                started_nxt = 1'b0;
              end
            endcase
          end
          r_ok   = success_nxt;
          r_perr = aborted_nxt;
        end
      end
      default: ;
    endcase
  end

  assign do_ins = go && ins_req && ins_ok;
  assign do_rem = go && rem_req && found;

  // cell row update: insert shifts up, remove shifts down
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      vals_nxt[i] = vals_r[i];
      if (do_ins && !lt[i]) begin
        if (i == 0) vals_nxt[i] = key;
        else if (lt[(i == 0) ? 0 : i - 1]) vals_nxt[i] = key;
        else vals_nxt[i] = vals_r[(i == 0) ? 0 : i - 1];
      end else if (do_rem && !lt[i] && i < CAP - 1) begin
        vals_nxt[i] = vals_r[(i < CAP - 1) ? i + 1 : i];
      end
    end
  end

  // stored count
  always_comb begin
    count_nxt = count_r;
    if (go && q_cmd.opcode == snsl_pkg::OP_CLR) count_nxt = '0;
    else if (do_ins) count_nxt = count_r + CW'(1);
    else if (do_rem) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAP; i++) vals_r[i] <= vals_nxt[i];
  end

  // control and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      acc_r     <= 64'd0;
      started_r <= 1'b0;
      success_r <= 1'b1;
      aborted_r <= 1'b0;
      ovld_r    <= 1'b0;
    end else begin
      if (go) begin
        count_r   <= count_nxt;
        acc_r     <= acc_nxt;
        started_r <= started_nxt;
        success_r <= success_nxt;
        aborted_r <= aborted_nxt;
      end
      if (go) ovld_r <= 1'b1;
      else if (out_ready) ovld_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (go) begin
      o_ok_r   <= r_ok;
      o_full_r <= r_full;
      o_min_r  <= r_min;
      o_cnt_r  <= count_nxt;
      o_perr_r <= r_perr;
      o_done_r <= r_done;
    end
  end

  assign out_valid       = ovld_r;
  assign out_ok          = o_ok_r;
  assign out_full_res    = o_full_r;
  assign out_min_value   = o_min_r;
  assign out_count       = o_cnt_r;
  assign out_parse_error = o_perr_r;
  assign out_parse_done  = o_done_r;

  // checks
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(CAP))
    else $error("count above capacity");
  a_abort_fail: assert property (@(posedge clk) disable iff (!rst_n) aborted_r |-> !success_r)
    else $error("aborted list still marked successful");
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    go && q_cmd.opcode == snsl_pkg::OP_CLR |=> count_r == '0)
    else $error("clear did not empty the set");
  a_abort_acc: assert property (@(posedge clk) disable iff (!rst_n)
    aborted_r |-> (acc_r == 64'd0 && !started_r))
    else $error("aborted list holds a pending number");
endmodule
